[hw/rtl/bss_pkg.sv]
// ---------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the bounded substring search core.
// ---------------------------------------------------------------------------
package bss_pkg;

    // default sizes
    localparam int NEEDLE_MAX_DEF   = 32;
    localparam int HAYSTACK_MAX_DEF = 65536;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 16;
    // holds a needle count for any needle size up to 64
    localparam int NCNT_W  = 7;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // item kinds
    localparam logic KIND_NEEDLE   = 1'b0;
    localparam logic KIND_HAYSTACK = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_value;
        logic              last;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             needle_overflow;
    } t_result;

    // needle status seen by the scan logic
    typedef struct packed {
        logic [NCNT_W-1:0] count;
        logic [NCNT_W-1:0] eff_len;
        logic              overflow;
        logic              closed;
    } t_needle_stat;

endpackage

[hw/rtl/bss_in_if.sv]
// ---------------------------------------------------------------------------
// bss_in_if
// Input channel: one needle or haystack byte per item.
// ---------------------------------------------------------------------------
interface bss_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;
    logic       last;

    modport source (output valid, kind, byte_value, last, input ready);
    modport sink   (input valid, kind, byte_value, last, output ready);
endinterface

[hw/rtl/bss_out_if.sv]
// ---------------------------------------------------------------------------
// bss_out_if
// Result channel: one search result per closed haystack.
// ---------------------------------------------------------------------------
interface bss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_position;
    logic        needle_overflow;

    modport source (output valid, found, match_position, needle_overflow, input ready);
    modport sink   (input valid, found, match_position, needle_overflow, output ready);
endinterface

[hw/rtl/bss_needle.sv]
// ---------------------------------------------------------------------------
// bss_needle
// Needle byte store with its counters and the parallel byte comparators.
// ---------------------------------------------------------------------------
module bss_needle
    import bss_pkg::*;
#(
    parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  t_item                 i_item,
    output logic [NEEDLE_MAX-1:0] o_eq,
    output t_needle_stat          o_stat
);

    localparam int LW = $clog2(NEEDLE_MAX + 1);

    logic [BYTE_W-1:0] r_store [NEEDLE_MAX];
    logic [LW-1:0]     r_count, n_count;
    logic [LW-1:0]     r_eff, n_eff;
    logic              r_term, n_term;
    logic              r_ovf, n_ovf;
    logic              r_closed, n_closed;

    logic [LW-1:0]     base_count;
    logic              wr_en;

    // a needle byte after a closed needle starts over from empty
    always_comb begin
        base_count = r_closed ? '0 : r_count;
        wr_en      = 1'b0;
        n_count    = r_count;
        n_eff      = r_eff;
        n_term     = r_term;
        n_ovf      = r_ovf;
        n_closed   = r_closed;
        if (i_fire) begin
            if (i_item.kind == KIND_NEEDLE) begin
                if (r_closed) begin
                    n_eff  = '0;
                    n_term = 1'b0;
                    n_ovf  = 1'b0;
                end
                n_count = base_count;
                if (base_count < LW'(NEEDLE_MAX)) begin
                    wr_en   = 1'b1;
                    n_count = base_count + LW'(1);
                    if (!n_term) begin
                        if (i_item.byte_value == '0) begin
                            n_term = 1'b1;
                        end else begin
                            n_eff = n_eff + LW'(1);
                        end
                    end
                end else begin
                    n_ovf = 1'b1;
                end
                n_closed = i_item.last;
            end else begin
                n_closed = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_eff    <= '0;
            r_term   <= 1'b0;
            r_ovf    <= 1'b0;
            r_closed <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_eff    <= n_eff;
            r_term   <= n_term;
            r_ovf    <= n_ovf;
            r_closed <= n_closed;
        end
    end

    // byte store, one write per needle item that fits
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            if (wr_en && (base_count == LW'(i))) begin
                r_store[i] <= i_item.byte_value;
            end
        end
    end

    // one comparator per needle byte, limited to the effective length
    always_comb begin
        for (int b = 0; b < NEEDLE_MAX; b++) begin
            o_eq[b] = (r_store[b] == i_item.byte_value) && (LW'(b) < r_eff);
        end
    end

    assign o_stat.count    = NCNT_W'(r_count);
    assign o_stat.eff_len  = NCNT_W'(r_eff);
    assign o_stat.overflow = r_ovf;
    assign o_stat.closed   = r_closed;

endmodule

[hw/rtl/bss_scan.sv]
// ---------------------------------------------------------------------------
// bss_scan
// Shift-and match vector, haystack position and first-match tracking.
// ---------------------------------------------------------------------------
module bss_scan
    import bss_pkg::*;
#(
    parameter int NEEDLE_MAX   = NEEDLE_MAX_DEF,
    parameter int HAYSTACK_MAX = HAYSTACK_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  t_item                 i_item,
    input  logic [NEEDLE_MAX-1:0] i_eq,
    input  t_needle_stat          i_stat,
    output t_result               o_result
);

    localparam int LW   = $clog2(NEEDLE_MAX + 1);
    localparam int HW   = $clog2(HAYSTACK_MAX + 1);
    localparam int SW   = (HW > POS_W) ? HW : POS_W;
    localparam int CMPW = (LW > HW) ? LW : HW;

    logic [NEEDLE_MAX-1:0] r_pm, n_pm;
    logic [HW-1:0]         r_pos, n_pos;
    logic                  r_mf, n_mf;
    logic [POS_W-1:0]      r_fi, n_fi;
    logic                  r_stop, n_stop;

    logic [LW-1:0]         len;
    logic [LW-1:0]         cnt;
    logic [NEEDLE_MAX-1:0] scan_pm;
    logic [NEEDLE_MAX-1:0] tail_vec;
    logic [SW-1:0]         start;
    logic                  hit;

    assign len = i_stat.eff_len[LW-1:0];
    assign cnt = i_stat.count[LW-1:0];

    // shift-and step and start index of a full match
    assign scan_pm  = ((r_pm << 1) | NEEDLE_MAX'(1)) & i_eq;
    assign tail_vec = scan_pm >> (len - LW'(1));
    assign start    = SW'(r_pos) + SW'(1) - SW'(len);

    always_comb begin
        n_pm     = r_pm;
        n_pos    = r_pos;
        n_mf     = r_mf;
        n_fi     = r_fi;
        n_stop   = r_stop;
        hit      = 1'b0;
        o_result = '0;
        if (i_fire) begin
            if (i_item.kind == KIND_NEEDLE) begin
                // a new needle abandons the haystack in progress
                if (i_stat.closed) begin
                    n_pm   = '0;
                    n_pos  = '0;
                    n_mf   = 1'b0;
                    n_fi   = '0;
                    n_stop = 1'b0;
                end
            end else begin
                if (r_pos < HW'(HAYSTACK_MAX)) begin
                    if (!r_stop) begin
                        if (i_item.byte_value == '0) begin
                            n_stop = 1'b1;
                        end else if (len == '0) begin
                            // empty needle matches at the first nonzero byte
                            if ((r_pos == '0) && !r_mf) begin
                                n_mf = 1'b1;
                                n_fi = '0;
                            end
                        end else begin
                            n_pm = scan_pm;
                            if (!r_mf && tail_vec[0]) begin
                                n_mf = 1'b1;
                                n_fi = (start > SW'(POS_MAX)) ? POS_MAX : start[POS_W-1:0];
                            end
                        end
                    end
                    n_pos = r_pos + HW'(1);
                end
                // closing byte: report and clear for the next haystack
                if (i_item.last) begin
                    hit                      = n_mf && (CMPW'(cnt) <= CMPW'(n_pos));
                    o_result.found           = hit;
                    o_result.match_position  = hit ? n_fi : '0;
                    o_result.needle_overflow = i_stat.overflow;
                    n_pm   = '0;
                    n_pos  = '0;
                    n_mf   = 1'b0;
                    n_fi   = '0;
                    n_stop = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm   <= '0;
            r_pos  <= '0;
            r_mf   <= 1'b0;
            r_fi   <= '0;
            r_stop <= 1'b0;
        end else begin
            r_pm   <= n_pm;
            r_pos  <= n_pos;
            r_mf   <= n_mf;
            r_fi   <= n_fi;
            r_stop <= n_stop;
        end
    end

endmodule

[hw/rtl/bounded_substring_search_core.sv]
// The closing haystack item passes the input register and then the result register
// before its result is valid. One item per cycle while the input is not stalled; the
// shift-and vector and its parallel byte comparators update once per accepted byte.
// A waiting result stalls the input only when the next item would also close a haystack.
// Reset is synchronous, active low; it clears the counters, flags and match
// vector, while the needle byte store keeps its contents.
// ---------------------------------------------------------------------------
// bounded_substring_search_core
// Streams a needle and then haystacks, reporting the first match per haystack.
// ---------------------------------------------------------------------------
module bounded_substring_search_core
    import bss_pkg::*;
#(
    parameter int NEEDLE_MAX   = NEEDLE_MAX_DEF,
    parameter int HAYSTACK_MAX = HAYSTACK_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bss_in_if.sink    i_in,
    bss_out_if.source o_out
);

    logic                  r_in_valid;
    t_item                 r_item;
    logic                  r_out_valid;
    t_result               r_res;

    logic                  produces;
    logic                  advance;
    logic [NEEDLE_MAX-1:0] eq;
    t_needle_stat          stat;
    t_result               result;

    // the registered item moves on unless its result would overwrite one waiting
    assign produces   = (r_item.kind == KIND_HAYSTACK) && r_item.last;
    assign advance    = r_in_valid && (!produces || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.kind       <= i_in.kind;
            r_item.byte_value <= i_in.byte_value;
            r_item.last       <= i_in.last;
        end
    end

    bss_needle #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_needle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_item),
        .o_eq    (eq),
        .o_stat  (stat)
    );

    bss_scan #(
        .NEEDLE_MAX   (NEEDLE_MAX),
        .HAYSTACK_MAX (HAYSTACK_MAX)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .i_eq     (eq),
        .i_stat   (stat),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produces) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produces) begin
            r_res <= result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.found           = r_res.found;
    assign o_out.match_position  = r_res.match_position;
    assign o_out.needle_overflow = r_res.needle_overflow;

endmodule

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_substring_search_core. A directed run covers
// byte extremes, zero bytes in needle and haystack, empty and short needles,
// open needles and abandoned haystacks; random needles and haystacks with
// planted matches follow. A scoreboard class predicts each search result and
// checks it field by field.
// ---------------------------------------------------------------------------
module testbench;
    import bss_pkg::*;

    localparam int NEEDLE_CAP   = NEEDLE_MAX_DEF;
    localparam int HAY_CAP      = HAYSTACK_MAX_DEF;
    localparam int RANDOM_END   = 1050;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    typedef logic [7:0] t_byte_q[$];

    // search predictor and store of pending search results
    class match_tracker;
        logic [7:0]            needle_bytes [NEEDLE_CAP];
        int unsigned           stored;
        int unsigned           cmp_len;
        bit                    zero_in_needle;
        bit                    needle_done;
        bit                    overflow;
        logic [NEEDLE_CAP-1:0] prefix_hits;
        int unsigned           hay_len;
        bit                    hit_seen;
        logic [POS_W-1:0]      hit_start;
        bit                    hay_stopped;
        t_result               expected_matches[$];
        int unsigned           n_errors;
        int unsigned           n_checked;
        int unsigned           n_found;
        int unsigned           n_overflow;

        function new();
            start_needle();
            clear_scan();
            n_errors   = 0;
            n_checked  = 0;
            n_found    = 0;
            n_overflow = 0;
        endfunction

        function void start_needle();
            stored         = 0;
            cmp_len        = 0;
            zero_in_needle = 1'b0;
            overflow       = 1'b0;
            needle_done    = 1'b0;
        endfunction

        function void clear_scan();
            prefix_hits = '0;
            hay_len     = 0;
            hit_seen    = 1'b0;
            hit_start   = '0;
            hay_stopped = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_matches.size();
        endfunction

        // advance the shift-and vector by one haystack byte
        function void scan_byte(logic [7:0] ch);
            logic [NEEDLE_CAP-1:0] eq;
            int unsigned           start;
            if (ch == 8'h00) begin
                hay_stopped = 1'b1;
            end else if (cmp_len == 0) begin
                // empty needle matches at the first nonzero byte only
                if (hay_len == 0 && !hit_seen) begin
                    hit_seen  = 1'b1;
                    hit_start = '0;
                end
            end else begin
                eq = '0;
                for (int b = 0; b < cmp_len; b++) begin
                    if (needle_bytes[b] == ch) eq[b] = 1'b1;
                end
                prefix_hits = ((prefix_hits << 1) | 1) & eq;
                if (!hit_seen && prefix_hits[cmp_len-1]) begin
                    start     = hay_len + 1 - cmp_len;
                    hit_seen  = 1'b1;
                    hit_start = (start > POS_MAX) ? POS_MAX : POS_W'(start);
                end
            end
        endfunction

        function void note_item(t_item it);
            t_result r;
            if (it.kind == KIND_NEEDLE) begin
                // a needle byte after a closed needle starts over
                if (needle_done) begin
                    start_needle();
                    clear_scan();
                end
                if (stored < NEEDLE_CAP) begin
                    needle_bytes[stored] = it.byte_value;
                    stored++;
                    if (!zero_in_needle) begin
                        if (it.byte_value == 8'h00) zero_in_needle = 1'b1;
                        else cmp_len++;
                    end
                end else begin
                    overflow = 1'b1;
                end
                if (it.last) needle_done = 1'b1;
            end else begin
                needle_done = 1'b1;
                // positions past the limit are ignored
                if (hay_len < HAY_CAP) begin
                    if (!hay_stopped) scan_byte(it.byte_value);
                    hay_len++;
                end
                if (it.last) begin
                    r.found           = hit_seen && (stored <= hay_len);
                    r.match_position  = r.found ? hit_start : '0;
                    r.needle_overflow = overflow;
                    expected_matches.push_back(r);
                    clear_scan();
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_matches.size() == 0) begin
                $error("result with no search pending: found=%0d position=%0d overflow=%0d",
                       got.found, got.match_position, got.needle_overflow);
                n_errors++;
            end else begin
                want = expected_matches.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    n_errors++;
                end
                if (got.match_position !== want.match_position) begin
                    $error("match_position: expected %0d, got %0d",
                           want.match_position, got.match_position);
                    n_errors++;
                end
                if (got.needle_overflow !== want.needle_overflow) begin
                    $error("needle_overflow: expected %0d, got %0d",
                           want.needle_overflow, got.needle_overflow);
                    n_errors++;
                end
                n_checked++;
                if (want.found) n_found++;
                if (want.needle_overflow) n_overflow++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bss_in_if  in_if ();
    bss_out_if out_if ();

    bounded_substring_search_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    match_tracker tracker = new();

    int unsigned n_sent     = 0;
    int          tx_gap_max = 4;
    int          rx_gap_max = 4;
    int          hold_req   = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // note accepted items and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                tracker.check_result(t_result'{out_if.found, out_if.match_position,
                                               out_if.needle_overflow});
            end
            if (in_if.valid && in_if.ready) begin
                tracker.note_item(t_item'{in_if.kind, in_if.byte_value, in_if.last});
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("bounded_substring_search_core regression: fail");
        $finish;
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        int stall;
        int holds_taken;
        out_if.ready = 1'b0;
        holds_taken  = 0;
        wait (i_rst_n);
        forever begin
            stall = $urandom_range(0, rx_gap_max);
            if (holds_taken != hold_req) begin
                holds_taken = hold_req;
                stall       = HOLD_CYCLES;
            end
            repeat (stall) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
        end
    end

    // one item with a random lead-in gap
    task automatic send_item(input logic kind, input logic [7:0] value, input logic last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.byte_value <= value;
        in_if.last       <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // a needle or haystack string, closed on its final byte if asked
    task automatic send_string(input logic kind, input t_byte_q s, input logic close);
        for (int i = 0; i < s.size(); i++) begin
            send_item(kind, s[i], close && (i == s.size() - 1));
        end
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    // mostly needle-alphabet bytes, some full-range and zero bytes
    function automatic logic [7:0] draw_char(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2);
        int p;
        p = $urandom_range(0, 99);
        if (p < 88) begin
            case ($urandom_range(0, 2))
                0: return a0;
                1: return a1;
                default: return a2;
            endcase
        end else if (p < 94) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'h00;
    endfunction

    task automatic run_directed();
        t_byte_q s;
        // byte extremes, match away from the start
        s = '{8'hFF, 8'h01};              send_string(KIND_NEEDLE, s, 1'b1);
        s = '{8'h01, 8'hFF, 8'h01};       send_string(KIND_HAYSTACK, s, 1'b1);
        // zero byte in the haystack stops the scan
        s = '{8'hFF, 8'h00, 8'hFF, 8'h01}; send_string(KIND_HAYSTACK, s, 1'b1);
        // haystack shorter than the needle
        s = '{8'hFF};                     send_string(KIND_HAYSTACK, s, 1'b1);
        // empty needle against nonzero and zero first bytes
        s = '{8'h00};                     send_string(KIND_NEEDLE, s, 1'b1);
        s = '{8'h41};                     send_string(KIND_HAYSTACK, s, 1'b1);
        s = '{8'h00};                     send_string(KIND_HAYSTACK, s, 1'b1);
        // haystack closes a needle left open
        s = '{8'h41};                     send_string(KIND_NEEDLE, s, 1'b0);
        s = '{8'h41};                     send_string(KIND_HAYSTACK, s, 1'b1);
        // new needle abandons an open haystack
        s = '{8'h42};                     send_string(KIND_HAYSTACK, s, 1'b0);
        s = '{8'h42};                     send_string(KIND_NEEDLE, s, 1'b1);
        s = '{8'h42};                     send_string(KIND_HAYSTACK, s, 1'b1);
        // zero inside the needle shortens the compare but not the size test
        s = '{8'h41, 8'h00, 8'h43};       send_string(KIND_NEEDLE, s, 1'b1);
        s = '{8'h41};                     send_string(KIND_HAYSTACK, s, 1'b1);
        s = '{8'h58, 8'h41, 8'h58};       send_string(KIND_HAYSTACK, s, 1'b1);
    endtask

    // receiver holds off while short haystacks keep closing
    task automatic pressure_burst();
        int saved_gap;
        saved_gap  = tx_gap_max;
        tx_gap_max = 0;
        hold_req   = hold_req + 1;
        repeat (10) send_item(KIND_HAYSTACK, 8'($urandom_range(1, 255)), 1'b1);
        tx_gap_max = saved_gap;
    endtask

    task automatic run_random();
        t_byte_q     needle;
        t_byte_q     hay;
        logic [7:0]  a0, a1, a2;
        int          n_len, h_len, pos, pick;
        bit          pressure_done;
        bit          pause_done;
        pressure_done = 1'b0;
        pause_done    = 1'b0;
        while (n_sent < RANDOM_END) begin
            // switch idle behavior now and then, including no idling at all
            if ($urandom_range(0, 9) == 0) tx_gap_max = $urandom_range(0, 1) ? 4 : 0;
            if ($urandom_range(0, 9) == 0) rx_gap_max = $urandom_range(0, 1) ? 4 : 0;
            a0 = 8'($urandom_range(1, 255));
            a1 = 8'($urandom_range(1, 255));
            a2 = 8'($urandom_range(1, 255));
            pick = $urandom_range(0, 99);
            if (pick < 70)      n_len = $urandom_range(1, 5);
            else if (pick < 90) n_len = $urandom_range(6, NEEDLE_CAP);
            else                n_len = $urandom_range(NEEDLE_CAP + 1, NEEDLE_CAP + 4);
            needle = {};
            repeat (n_len) needle.push_back(draw_char(a0, a1, a2));
            // now and then the needle is left open
            send_string(KIND_NEEDLE, needle, $urandom_range(0, 9) != 0);
            repeat ($urandom_range(1, 4)) begin
                h_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16)
                                                     : $urandom_range(17, 48);
                hay = {};
                repeat (h_len) hay.push_back(draw_char(a0, a1, a2));
                // now and then plant the needle at a random place
                if (h_len >= n_len && n_len <= NEEDLE_CAP && $urandom_range(0, 1)) begin
                    pos = $urandom_range(0, h_len - n_len);
                    for (int i = 0; i < n_len; i++) hay[pos + i] = needle[i];
                end
                send_string(KIND_HAYSTACK, hay, $urandom_range(0, 19) != 0);
            end
            if (!pressure_done && n_sent > 400) begin
                pressure_burst();
                pressure_done = 1'b1;
            end
            if (!pause_done && n_sent > 700) begin
                drain();
                pause_done = 1'b1;
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_NEEDLE;
        in_if.byte_value = 8'h00;
        in_if.last       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        drain();
        run_random();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d items; checked %0d search results, %0d found,",
                 n_sent, tracker.n_checked, tracker.n_found);
        $display("%0d with needle overflow; covered open needles, abandoned haystacks, a stalled input",
                 tracker.n_overflow);
        if (tracker.n_errors == 0 && tracker.pending() == 0) begin
            $display("bounded_substring_search_core regression: pass");
        end else begin
            $display("bounded_substring_search_core regression: fail");
        end
        $finish;
    end

endmodule
